/* rtl/core/klr_pkg.sv */
// ----------------------------------------------------------------------------
// klr_pkg
// Shared constants, register indexes and types of the k-out-of-n
// reliability evaluator.
// ----------------------------------------------------------------------------
package klr_pkg;

    localparam int MAX_COMPONENTS = 16;
    localparam int FRAC_BITS      = 31;
    localparam int DATA_W         = 32;
    localparam int CFG_W          = 5;
    localparam int IDX_W          = 2;
    localparam int CNT_W          = $clog2(MAX_COMPONENTS + 1);
    localparam int CMP_W          = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int COEF_W         = MAX_COMPONENTS;
    localparam int TERM_W         = DATA_W + COEF_W;
    localparam int SUM_W          = TERM_W + CNT_W;
    localparam int PROD_W         = 2 * DATA_W;

    localparam logic [DATA_W-1:0] ONE      = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(64'd1 << (FRAC_BITS - 1));

    typedef logic [IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx REG_NUM_COMPONENTS = 2'd0;
    localparam t_cfg_idx REG_MIN_WORKING    = 2'd1;
    localparam t_cfg_idx REG_COUNT_FAILURES = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [CFG_W-1:0] k;
        logic             fail;
    } t_eval_cfg;

endpackage

/* rtl/core/klr_mul_unit.sv */
// ----------------------------------------------------------------------------
// klr_mul_unit
// Shared 32x32 multiplier with a round-to-nearest fixed-point output.
// ----------------------------------------------------------------------------
module klr_mul_unit (
    input  logic [klr_pkg::DATA_W-1:0] i_a,
    input  logic [klr_pkg::DATA_W-1:0] i_b,
    output logic [klr_pkg::PROD_W-1:0] o_prod,
    output logic [klr_pkg::DATA_W-1:0] o_round
);

    logic [klr_pkg::PROD_W-1:0] w_rsum;

    assign o_prod  = klr_pkg::PROD_W'(i_a) * klr_pkg::PROD_W'(i_b);
    assign w_rsum  = o_prod + klr_pkg::HALF_LSB;
    assign o_round = klr_pkg::DATA_W'(w_rsum >> klr_pkg::FRAC_BITS);

endmodule

/* rtl/core/klr_binom_table.sv */
// ----------------------------------------------------------------------------
// klr_binom_table
// Binomial coefficient row C(n, 0..MAX), rebuilt by Pascal passes, one pass
// per cycle, after n is written.
// ----------------------------------------------------------------------------
module klr_binom_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic [klr_pkg::CNT_W-1:0]   i_n,
    input  logic [klr_pkg::CNT_W-1:0]   i_idx,
    output logic [klr_pkg::COEF_W-1:0]  o_coef,
    output logic                        o_busy
);

    logic [klr_pkg::COEF_W-1:0] r_tab [0:klr_pkg::MAX_COMPONENTS];
    logic [klr_pkg::CNT_W-1:0]  r_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= klr_pkg::MAX_COMPONENTS; j++) begin
                r_tab[j] <= (j <= 1) ? klr_pkg::COEF_W'(1) : '0;
            end
            r_left <= '0;
        end else if (i_load) begin
            for (int j = 0; j <= klr_pkg::MAX_COMPONENTS; j++) begin
                r_tab[j] <= (j == 0) ? klr_pkg::COEF_W'(1) : '0;
            end
            r_left <= i_n;
        end else if (r_left != '0) begin
            for (int j = 1; j <= klr_pkg::MAX_COMPONENTS; j++) begin
                r_tab[j] <= r_tab[j] + r_tab[j-1];
            end
            r_left <= r_left - 1'b1;
        end
    end

    assign o_coef = r_tab[i_idx];
    assign o_busy = (r_left != '0);

endmodule

/* rtl/core/klr_eval.sv */
// ----------------------------------------------------------------------------
// klr_eval
// Sequencer that builds each power product through the shared multiplier,
// weights it by its coefficient and accumulates the system reliability.
// ----------------------------------------------------------------------------
module klr_eval (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [klr_pkg::DATA_W-1:0]  i_rel,
    input  klr_pkg::t_eval_cfg          i_cfg,
    output logic [klr_pkg::CNT_W-1:0]   o_coef_idx,
    input  logic [klr_pkg::COEF_W-1:0]  i_coef,
    output logic                        o_idle,
    output logic                        o_done,
    output logic [klr_pkg::DATA_W-1:0]  o_result,
    input  logic                        i_ack
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_ACC  = 5'b00100,
        S_ADD  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state                     r_state, n_state;
    logic [klr_pkg::DATA_W-1:0] r_first, n_first;
    logic [klr_pkg::DATA_W-1:0] r_second, n_second;
    logic [klr_pkg::DATA_W-1:0] r_p, n_p;
    logic [klr_pkg::CNT_W-1:0]  r_i, n_i;
    logic [klr_pkg::CNT_W-1:0]  r_c, n_c;
    logic [klr_pkg::TERM_W-1:0] r_term, n_term;
    logic [klr_pkg::SUM_W-1:0]  r_sum, n_sum;

    logic [klr_pkg::DATA_W-1:0] w_rel, w_unrel, w_mul_b, w_round;
    logic [klr_pkg::PROD_W-1:0] w_prod;
    logic                       w_empty;
    logic [klr_pkg::SUM_W-1:0]  w_one;

    assign w_rel   = (i_rel > klr_pkg::ONE) ? klr_pkg::ONE : i_rel;
    assign w_unrel = klr_pkg::ONE - w_rel;
    assign w_empty = klr_pkg::CMP_W'(i_cfg.k) > klr_pkg::CMP_W'(i_cfg.n);
    assign w_one   = klr_pkg::SUM_W'(klr_pkg::ONE);

    assign w_mul_b = (r_state == S_ACC) ? klr_pkg::DATA_W'(i_coef)
                   : ((r_i < r_c) ? r_first : r_second);

    klr_mul_unit u_mul (
        .i_a     (r_p),
        .i_b     (w_mul_b),
        .o_prod  (w_prod),
        .o_round (w_round)
    );

    always_comb begin
        n_state  = r_state;
        n_first  = r_first;
        n_second = r_second;
        n_p      = r_p;
        n_i      = r_i;
        n_c      = r_c;
        n_term   = r_term;
        n_sum    = r_sum;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_first  = i_cfg.fail ? w_unrel : w_rel;
                    n_second = i_cfg.fail ? w_rel : w_unrel;
                    n_sum    = '0;
                    n_p      = klr_pkg::ONE;
                    n_i      = '0;
                    n_c      = klr_pkg::CNT_W'(i_cfg.k);
                    if (w_empty) begin
                        n_state = S_DONE;
                    end else if (i_cfg.n == '0) begin
                        n_state = S_ACC;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_p = w_round;
                n_i = r_i + 1'b1;
                if (r_i == i_cfg.n - 1'b1) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                n_term  = klr_pkg::TERM_W'(w_prod);
                n_state = S_ADD;
            end
            S_ADD: begin
                n_sum = r_sum + klr_pkg::SUM_W'(r_term);
                if (r_c == i_cfg.n) begin
                    n_state = S_DONE;
                end else begin
                    n_c     = r_c + 1'b1;
                    n_p     = klr_pkg::ONE;
                    n_i     = '0;
                    n_state = S_MUL;
                end
            end
            S_DONE: begin
                if (i_ack) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_first  <= n_first;
        r_second <= n_second;
        r_p      <= n_p;
        r_i      <= n_i;
        r_c      <= n_c;
        r_term   <= n_term;
        r_sum    <= n_sum;
    end

    always_comb begin
        if (i_cfg.fail) begin
            o_result = (r_sum >= w_one) ? '0
                     : klr_pkg::DATA_W'(w_one - r_sum);
        end else begin
            o_result = (r_sum > w_one) ? klr_pkg::ONE : klr_pkg::DATA_W'(r_sum);
        end
    end

    assign o_coef_idx = r_c;
    assign o_idle     = (r_state == S_IDLE);
    assign o_done     = (r_state == S_DONE);

    a_mul_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_i < i_cfg.n))
        else $error("multiply index beyond component count");

    a_term_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ACC || r_state == S_ADD) |-> (r_c <= i_cfg.n))
        else $error("term index beyond component count");

    a_result_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result <= klr_pkg::ONE))
        else $error("result above one");

endmodule

/* rtl/core/identical_k_of_n_reliability_top.sv */
// ----------------------------------------------------------------------------
// identical_k_of_n_reliability_top
// k-out-of-n system reliability of identical components, Q1.31 in and out.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one component reliability
// (i_component_rel); a transfer happens when valid is high and stall is low.
// Output channel: o_out_valid / i_out_stall carry one system reliability
// (o_system_rel) per input transfer, in order.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_idx
// (0: n, 1: k, 2: failure mode); index 3 is ignored. Write only while idle.
// A write of n rebuilds the coefficient row, with the input stalled.
// Sequencing: one shared multiplier runs every product. Each term is
// built by repeated multiplies, then weighted by its coefficient and
// accumulated; with k > n the sequencer goes straight to done. The next
// item can transfer once the result has moved to the output register;
// one item is in work at a time.
// The result sits in an output register; the next item is accepted while
// it waits. A stalled receiver holds the result and, once the next item
// finishes, holds the sequencer in its done state.
// Reset: n = 1, k = 1, working mode, coefficient row 1, both channels empty.
// ----------------------------------------------------------------------------
module identical_k_of_n_reliability_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [klr_pkg::DATA_W-1:0]  i_component_rel,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [klr_pkg::DATA_W-1:0]  o_system_rel,
    input  logic                        i_cfg_we,
    input  klr_pkg::t_cfg_idx           i_cfg_idx,
    input  logic [klr_pkg::CFG_W-1:0]   i_cfg_data
);

    klr_pkg::t_eval_cfg          r_cfg;
    logic                        r_out_valid;
    logic [klr_pkg::DATA_W-1:0]  r_system_rel;

    logic                        w_load_n;
    logic [klr_pkg::CNT_W-1:0]   w_n_clamped;
    logic [klr_pkg::CNT_W-1:0]   w_coef_idx;
    logic [klr_pkg::COEF_W-1:0]  w_coef;
    logic                        w_tab_busy;
    logic                        w_idle, w_done, w_load_out, w_in_xfer;
    logic [klr_pkg::DATA_W-1:0]  w_result;

    assign w_n_clamped = (int'(i_cfg_data) > klr_pkg::MAX_COMPONENTS)
                       ? klr_pkg::CNT_W'(klr_pkg::MAX_COMPONENTS)
                       : klr_pkg::CNT_W'(i_cfg_data);
    assign w_load_n    = i_cfg_we && (i_cfg_idx == klr_pkg::REG_NUM_COMPONENTS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.n    <= klr_pkg::CNT_W'(1);
            r_cfg.k    <= klr_pkg::CFG_W'(1);
            r_cfg.fail <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                klr_pkg::REG_NUM_COMPONENTS: r_cfg.n    <= w_n_clamped;
                klr_pkg::REG_MIN_WORKING:    r_cfg.k    <= i_cfg_data;
                klr_pkg::REG_COUNT_FAILURES: r_cfg.fail <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    klr_binom_table u_tab (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load_n),
        .i_n     (w_n_clamped),
        .i_idx   (w_coef_idx),
        .o_coef  (w_coef),
        .o_busy  (w_tab_busy)
    );

    assign o_in_stall = !w_idle || w_tab_busy;
    assign w_in_xfer  = i_in_valid && !o_in_stall;

    klr_eval u_eval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_xfer),
        .i_rel      (i_component_rel),
        .i_cfg      (r_cfg),
        .o_coef_idx (w_coef_idx),
        .i_coef     (w_coef),
        .o_idle     (w_idle),
        .o_done     (w_done),
        .o_result   (w_result),
        .i_ack      (w_load_out)
    );

    assign w_load_out = w_done && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_load_out) begin
            r_system_rel <= w_result;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_system_rel = r_system_rel;

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the k-out-of-n reliability evaluator. Directed
// samples cover the fixed-point extremes and the corner settings of n and k
// (no components, n past the table, k zero, k above n, both modes); random
// phases then reprogram the block between bursts of samples. Every result is
// checked against a bit-exact Q1.31 predictor under bursty input and
// patterned output stall.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam klr_pkg::t_cfg_idx REG_UNUSED = 2'd3;
    localparam int         HOLD_OFF_CYCLES = 1500;
    localparam int         DRAIN_CYCLES    = 320;
    localparam int         RANDOM_ITEMS    = 700;
    localparam logic [63:0] ONE_Q          = 64'd1 << klr_pkg::FRAC_BITS;
    localparam logic [63:0] HALF_Q         = 64'd1 << (klr_pkg::FRAC_BITS - 1);

    typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_SOLID} t_stall_mode;

    logic                       i_clk     = 1'b0;
    logic                       i_rst_n   = 1'b0;
    logic                       in_valid  = 1'b0;
    logic [klr_pkg::DATA_W-1:0] in_rel    = '0;
    logic                       out_stall = 1'b0;
    logic                       cfg_we    = 1'b0;
    klr_pkg::t_cfg_idx          cfg_idx   = klr_pkg::REG_NUM_COMPONENTS;
    logic [klr_pkg::CFG_W-1:0]  cfg_data  = '0;
    logic                       o_in_stall;
    logic                       o_out_valid;
    logic [klr_pkg::DATA_W-1:0] o_system_rel;

    // configuration mirror
    logic [klr_pkg::CFG_W-1:0] cfg_n;
    logic [klr_pkg::CFG_W-1:0] cfg_k;
    logic                      cfg_fail;
    logic [63:0]               binom_row [0:klr_pkg::MAX_COMPONENTS];

    logic [klr_pkg::DATA_W-1:0] rel_pending_q [$];
    logic [klr_pkg::DATA_W-1:0] sys_rel_expected_q [$];
    logic [klr_pkg::DATA_W-1:0] exp_rel;
    int                errors     = 0;
    int                burst_left = 1;
    int                gap_left   = 0;
    int                hold_left  = 0;
    int                pattern_left = 0;
    t_stall_mode       stall_mode = STALL_NONE;
    logic              hold_off_go = 1'b0;

    identical_k_of_n_reliability_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (o_in_stall),
        .i_component_rel (in_rel),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (out_stall),
        .o_system_rel    (o_system_rel),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic int capped_n(logic [klr_pkg::CFG_W-1:0] n);
        return (n > klr_pkg::MAX_COMPONENTS) ? klr_pkg::MAX_COMPONENTS : int'(n);
    endfunction

    function automatic void rebuild_binom_row();
        int top;
        top = capped_n(cfg_n);
        foreach (binom_row[j]) binom_row[j] = 64'd0;
        binom_row[0] = 64'd1;
        for (int i = 1; i <= top; i++)
            for (int j = i; j >= 1; j--)
                binom_row[j] = binom_row[j] + binom_row[j-1];
    endfunction

    // rounded Q1.31 product, ties upward; operands never exceed one
    function automatic logic [63:0] q_mul(logic [63:0] a, logic [63:0] b);
        logic [63:0] prod;
        prod = a * b + HALF_Q;
        return prod >> klr_pkg::FRAC_BITS;
    endfunction

    // terms stay below 2^46, so the 64-bit sum cannot overflow
    function automatic logic [klr_pkg::DATA_W-1:0] predict_system_rel(
        logic [klr_pkg::DATA_W-1:0] rel_in);
        logic [63:0] r;
        logic [63:0] counted;
        logic [63:0] other;
        logic [63:0] p;
        logic [63:0] acc;
        logic [63:0] res;
        int          n;
        r = (rel_in > ONE_Q) ? ONE_Q : 64'(rel_in);
        counted = cfg_fail ? ONE_Q - r : r;
        other   = cfg_fail ? r : ONE_Q - r;
        n = capped_n(cfg_n);
        acc = 64'd0;
        for (int c = int'(cfg_k); c <= n; c++) begin
            p = ONE_Q;
            for (int i = 0; i < c; i++) p = q_mul(p, counted);
            for (int i = c; i < n; i++) p = q_mul(p, other);
            acc = acc + binom_row[c] * p;
        end
        if (cfg_fail)
            res = (acc >= ONE_Q) ? 64'd0 : ONE_Q - acc;
        else
            res = acc;
        if (res > ONE_Q) res = ONE_Q;
        return res[klr_pkg::DATA_W-1:0];
    endfunction

    // input driver: bursts of transfers separated by random gaps
    always @(posedge i_clk) begin
        if (in_valid && !o_in_stall)
            sys_rel_expected_q.push_back(predict_system_rel(in_rel));
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || !o_in_stall) begin
            if (gap_left > 0 || rel_pending_q.size() == 0) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else begin
                in_valid <= 1'b1;
                in_rel   <= rel_pending_q.pop_front();
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 30);
                    if ($urandom_range(0, 9) < 4)
                        gap_left <= 0;
                    else if ($urandom_range(0, 19) == 0)
                        gap_left <= $urandom_range(50, 320);
                    else
                        gap_left <= $urandom_range(1, 8);
                end
            end
        end
    end

    // output monitor and stall pattern
    always @(posedge i_clk) begin
        if (o_out_valid && !out_stall) begin
            if (sys_rel_expected_q.size() == 0) begin
                errors++;
                $display("%0t ns: system_rel transfer with nothing expected, actual %h",
                         $time, o_system_rel);
            end else begin
                exp_rel = sys_rel_expected_q.pop_front();
                if (o_system_rel !== exp_rel) begin
                    errors++;
                    $display("%0t ns: system_rel mismatch, expected %h actual %h",
                             $time, exp_rel, o_system_rel);
                end
            end
        end
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_off_go) begin
            hold_left <= HOLD_OFF_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left > 1);
        end else begin
            if (pattern_left == 0) begin
                stall_mode   <= t_stall_mode'($urandom_range(0, 3));
                pattern_left <= $urandom_range(1, 200);
            end else begin
                pattern_left <= pattern_left - 1;
            end
            case (stall_mode)
                STALL_NONE:  out_stall <= 1'b0;
                STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                default:     out_stall <= 1'b1;
            endcase
        end
    end

    task automatic program_reg(klr_pkg::t_cfg_idx idx, logic [klr_pkg::CFG_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            klr_pkg::REG_NUM_COMPONENTS: begin
                cfg_n = data;
                rebuild_binom_row();
            end
            klr_pkg::REG_MIN_WORKING:    cfg_k = data;
            klr_pkg::REG_COUNT_FAILURES: cfg_fail = data[0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic program_all(logic [klr_pkg::CFG_W-1:0] n, logic [klr_pkg::CFG_W-1:0] k,
                               logic fail);
        logic [klr_pkg::CFG_W-1:0] fail_word;
        fail_word = klr_pkg::CFG_W'($urandom) & ~klr_pkg::CFG_W'(1) | klr_pkg::CFG_W'(fail);
        program_reg(klr_pkg::REG_NUM_COMPONENTS, n);
        program_reg(klr_pkg::REG_MIN_WORKING, k);
        program_reg(klr_pkg::REG_COUNT_FAILURES, fail_word);
    endtask

    task automatic wait_drained();
        while (rel_pending_q.size() != 0 || in_valid || sys_rel_expected_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        logic [klr_pkg::CFG_W-1:0]  n;
        logic [klr_pkg::CFG_W-1:0]  k;
        logic [klr_pkg::DATA_W-1:0] r;
        int                sent;
        int                batch;
        int                top;

        cfg_n    = klr_pkg::CFG_W'(1);
        cfg_k    = klr_pkg::CFG_W'(1);
        cfg_fail = 1'b0;
        rebuild_binom_row();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: n = 1, k = 1, working mode
        rel_pending_q = '{32'h0000_0000, klr_pkg::ONE, 32'h0000_0001, klr_pkg::ONE - 1,
                          32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h4000_0000};
        wait_drained();

        program_all(5'd16, 5'd8, 1'b0);
        rel_pending_q = '{32'h6000_0000, 32'h7FFF_FFFF};
        wait_drained();

        program_all(5'd16, 5'd16, 1'b1);
        rel_pending_q = '{32'h0000_0001, 32'h4000_0000};
        wait_drained();

        // no components, k zero
        program_all(5'd0, 5'd0, 1'b0);
        rel_pending_q = '{32'h3000_0000};
        wait_drained();
        program_reg(klr_pkg::REG_COUNT_FAILURES, 5'h1F);
        rel_pending_q = '{32'h3000_0000};
        wait_drained();

        // n past the table size
        program_all(5'd31, 5'd1, 1'b1);
        rel_pending_q = '{32'h7000_0000};
        wait_drained();

        // k above n, both modes
        program_all(5'd3, 5'd20, 1'b0);
        rel_pending_q = '{32'h4000_0000};
        wait_drained();
        program_reg(klr_pkg::REG_COUNT_FAILURES, 5'd1);
        rel_pending_q = '{32'h4000_0000};
        wait_drained();

        // full sum at the largest n, then a write to the unused index
        program_all(5'd16, 5'd0, 1'b0);
        rel_pending_q = '{32'h2AAA_AAAB};
        wait_drained();
        program_reg(REG_UNUSED, 5'h1F);
        rel_pending_q = '{32'h5000_0000};
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        program_all(5'd4, 5'd2, 1'b0);
        for (int i = 0; i < 12; i++)
            rel_pending_q.push_back($urandom_range(0, klr_pkg::ONE));
        @(posedge i_clk);
        hold_off_go <= 1'b1;
        @(posedge i_clk);
        hold_off_go <= 1'b0;
        wait_drained();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 19))
                0:          n = 5'd0;
                1:          n = klr_pkg::CFG_W'($urandom_range(17, 31));
                2, 3, 4, 5: n = klr_pkg::CFG_W'($urandom_range(9, 16));
                default:    n = klr_pkg::CFG_W'($urandom_range(1, 8));
            endcase
            top = capped_n(n);
            if ($urandom_range(0, 9) == 0)
                k = klr_pkg::CFG_W'($urandom_range(0, 31));
            else
                k = klr_pkg::CFG_W'($urandom_range(0, top + 1));
            if ($urandom_range(0, 7) == 0)
                program_reg(REG_UNUSED, klr_pkg::CFG_W'($urandom));
            program_all(n, k, 1'($urandom_range(0, 1)));
            batch = $urandom_range(10, 50);
            for (int i = 0; i < batch; i++) begin
                case ($urandom_range(0, 9))
                    0: r = $urandom;
                    1: case ($urandom_range(0, 3))
                           0:       r = 32'h0000_0000;
                           1:       r = klr_pkg::ONE;
                           2:       r = 32'h0000_0001;
                           default: r = klr_pkg::ONE - 1;
                       endcase
                    default: r = $urandom_range(0, klr_pkg::ONE);
                endcase
                rel_pending_q.push_back(r);
            end
            sent += batch;
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sys_rel_expected_q.size() != 0) begin
            errors++;
            $display("%0t ns: %0d system_rel results never arrived",
                     $time, sys_rel_expected_q.size());
        end
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/klr_pkg.sv
rtl/core/klr_mul_unit.sv
rtl/core/klr_binom_table.sv
rtl/core/klr_eval.sv
rtl/core/identical_k_of_n_reliability_top.sv
tb/sv/testbench.sv
